@@ rtl/kcl_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// kcl_pkg
// Shared types, codes and constants of the keypad code lock controller.
// ---------------------------------------------------------------------------
package kcl_pkg;

  // code length and derived widths
  localparam int CODE_DIGITS = 4;
  localparam int CNT_W       = $clog2(CODE_DIGITS + 1);

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // configuration reset values
  localparam logic        RST_FSM_ENABLE   = 1'b1;
  localparam logic [15:0] RST_INIT_LOCK    = 16'd6000;
  localparam logic [15:0] RST_LOCK_CAP     = 16'd30000;
  localparam logic [1:0]  RST_MAX_WRONG    = 2'd3;
  localparam logic [15:0] RST_MSG_TICKS    = 16'd100;
  localparam logic [1:0]  WRONG_SAT        = 2'd3;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_FSM_ENABLE = 3'd0;
  localparam logic [2:0] REG_INIT_LOCK  = 3'd1;
  localparam logic [2:0] REG_LOCK_CAP   = 3'd2;
  localparam logic [2:0] REG_MAX_WRONG  = 3'd3;
  localparam logic [2:0] REG_MSG_TICKS  = 3'd4;

  // raw key codes
  localparam logic [3:0] KEY_STAR_CODE = 4'd10;
  localparam logic [3:0] KEY_HASH_CODE = 4'd11;
  localparam logic [3:0] KEY_MAX_DIGIT = 4'd9;

  typedef enum logic [1:0] {
    REQ_SERVICE = 2'd0,
    REQ_STOP    = 2'd1,
    REQ_SHOW    = 2'd2,
    REQ_NOP     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    KC_NONE  = 2'd0,
    KC_DIGIT = 2'd1,
    KC_STAR  = 2'd2,
    KC_HASH  = 2'd3
  } key_cls_t;

  typedef enum logic [1:0] {
    PH_INPUT  = 2'd0,
    PH_CHECK  = 2'd1,
    PH_LOCKED = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    MD_NORMAL  = 2'd0,
    MD_OLD     = 2'd1,
    MD_NEW     = 2'd2,
    MD_CONFIRM = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    MSG_NONE       = 4'd0,
    MSG_ENTER      = 4'd1,
    MSG_LOCK_ENDED = 4'd2,
    MSG_OLD_PROMPT = 4'd3,
    MSG_CANCELLED  = 4'd4,
    MSG_DOOR_OPEN  = 4'd5,
    MSG_GRANTED    = 4'd6,
    MSG_WRONG      = 4'd7,
    MSG_LOCKED     = 4'd8,
    MSG_NEW_PROMPT = 4'd9,
    MSG_WRONG_OLD  = 4'd10,
    MSG_CONFIRM    = 4'd11,
    MSG_CHANGED    = 4'd12,
    MSG_MISMATCH   = 4'd13
  } msg_t;

  typedef logic [CODE_DIGITS-1:0][3:0] code_t;

  // classified request as it sits in the queue
  typedef struct packed {
    req_t       req;
    key_cls_t   cls;
    logic [3:0] digit;
    logic       door;
    logic       tick;
  } item_t;

  // configuration seen by the back part
  typedef struct packed {
    logic        fsm_enable;
    logic [15:0] init_lock;
    logic [15:0] lock_cap;
    logic [1:0]  max_wrong;
    logic [15:0] msg_ticks;
  } cfg_t;

  // stored code after reset: digit i is (i+1) mod 10
  function automatic code_t reset_code();
    code_t c;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      c[i] = 4'((i + 1) % 10);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/kcl_front.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// kcl_front
// Input side: takes request beats and classifies request and key.
// ---------------------------------------------------------------------------
module kcl_front import kcl_pkg::*; (
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_req_type,
  input  wire logic [3:0] in_key_code,
  input  wire logic       in_door_open,
  input  wire logic       in_tick,
  input  wire logic       q_full,
  output logic            q_push,
  output item_t           q_item
);

  // stall while the queue has no room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // key class: codes twelve to fifteen count as no key
  always_comb begin
    q_item.req   = req_t'(in_req_type);
    q_item.digit = in_key_code;
    q_item.door  = in_door_open;
    q_item.tick  = in_tick;
    if (in_key_code <= KEY_MAX_DIGIT) begin
      q_item.cls = KC_DIGIT;
    end else if (in_key_code == KEY_STAR_CODE) begin
      q_item.cls = KC_STAR;
    end else if (in_key_code == KEY_HASH_CODE) begin
      q_item.cls = KC_HASH;
    end else begin
      q_item.cls = KC_NONE;
    end
  end

endmodule
`default_nettype wire

@@ rtl/kcl_queue.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// kcl_queue
// Short register queue between the classifying front and the back part.
// ---------------------------------------------------------------------------
module kcl_queue import kcl_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output item_t      pop_item,
  output logic       empty
);

  item_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

@@ rtl/kcl_core.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// kcl_core
// Back part: runs one request per cycle against the lock state unless
// out_stall holds the result beat that it keeps in an output register.
// ---------------------------------------------------------------------------
module kcl_core import kcl_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  q_empty,
  input  wire item_t q_item,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output logic       out_access_granted,
  output logic       out_locked_out,
  output logic       out_intruder_alarm,
  output logic [2:0] out_digits_shown,
  output logic [3:0] out_message,
  output logic [1:0] out_entry_mode
);

  // lock state
  code_t             stored_r, stored_nxt;
  code_t             entry_r, entry_nxt;
  code_t             cand_r, cand_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  phase_t            phase_r, phase_nxt;
  mode_t             mode_r, mode_nxt;
  logic              showing_r, showing_nxt;
  logic [1:0]        wrong_r, wrong_nxt;
  logic [16:0]       lock_len_r, lock_len_nxt;
  logic [16:0]       lock_rem_r, lock_rem_nxt;
  logic [15:0]       msg_rem_r, msg_rem_nxt;
  logic              alarm_r, alarm_nxt;
  logic              held_r, held_nxt;
  logic              clr_pend_r, clr_pend_nxt;
  logic              chg_pend_r, chg_pend_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic              granted_r;
  logic              locked_r;
  logic              alarm_out_r;
  logic [2:0]        shown_r;
  msg_t              message_r;
  mode_t             mode_out_r;
  msg_t              msg_c;
  logic              granted_c;

  // take a queued request when the result slot is free or being taken
  assign q_pop = !q_empty && (!out_valid_r || !out_stall);

  // one request against the state
  always_comb begin
    logic             go;
    logic             got_digit;
    logic             do_check;
    logic [16:0]      lr;
    logic [15:0]      mr;
    logic [1:0]       w;
    code_t            ent;
    logic [CNT_W-1:0] cnt;
    mode_t            md;

    go        = 1'b0;
    got_digit = 1'b0;
    do_check  = 1'b0;
    lr        = lock_rem_r;
    mr        = msg_rem_r;
    w         = wrong_r;
    ent       = entry_r;
    cnt       = count_r;
    md        = mode_r;

    stored_nxt   = stored_r;
    cand_nxt     = cand_r;
    phase_nxt    = phase_r;
    showing_nxt  = showing_r;
    lock_len_nxt = lock_len_r;
    lock_rem_nxt = lock_rem_r;
    msg_rem_nxt  = msg_rem_r;
    alarm_nxt    = alarm_r;
    held_nxt     = held_r;
    clr_pend_nxt = clr_pend_r;
    chg_pend_nxt = chg_pend_r;
    msg_c        = MSG_NONE;
    granted_c    = 1'b0;

    case (q_item.req)
      REQ_SERVICE: begin
        if (cfg.fsm_enable) begin
          if (showing_r) begin
            // message hold timer
            if (q_item.tick && mr != '0) begin
              mr = mr - 1'b1;
            end
            msg_rem_nxt = mr;
            if (mr == '0) begin
              showing_nxt = 1'b0;
              md          = MD_NORMAL;
              phase_nxt   = PH_INPUT;
              ent         = '0;
              cnt         = '0;
              msg_c       = MSG_ENTER;
            end
          end else begin
            go = 1'b1;
            // lockout timer
            if (phase_r == PH_LOCKED) begin
              if (q_item.tick && lr != '0) begin
                lr = lr - 1'b1;
              end
              lock_rem_nxt = lr;
              if (lr != '0) begin
                go = 1'b0;
              end else begin
                w         = '0;
                alarm_nxt = 1'b0;
                ent       = '0;
                cnt       = '0;
                msg_c     = MSG_LOCK_ENDED;
              end
            end
          end
          if (go) begin
            phase_nxt = PH_INPUT;
            // '#' from the previous step toggles code change
            if (chg_pend_r) begin
              chg_pend_nxt = 1'b0;
              if (md == MD_NORMAL) begin
                md    = MD_OLD;
                msg_c = MSG_OLD_PROMPT;
              end else begin
                md    = MD_NORMAL;
                msg_c = MSG_CANCELLED;
              end
              ent = '0;
              cnt = '0;
            end
            // '*' from the previous step clears the entry
            if (clr_pend_r) begin
              clr_pend_nxt = 1'b0;
              if (md != MD_NORMAL || !q_item.door) begin
                ent = '0;
                cnt = '0;
              end
            end
            // press edge detection
            if (q_item.cls != KC_NONE) begin
              if (!held_r) begin
                held_nxt = 1'b1;
                case (q_item.cls)
                  KC_DIGIT: got_digit    = 1'b1;
                  KC_STAR:  clr_pend_nxt = 1'b1;
                  KC_HASH:  chg_pend_nxt = 1'b1;
                  default:  got_digit    = 1'b0;
                endcase
              end
            end else begin
              held_nxt = 1'b0;
            end
            // digit shift into the entry
            if (got_digit) begin
              if (md != MD_NORMAL || !q_item.door) begin
                for (int i = 0; i < CODE_DIGITS - 1; i++) begin
                  ent[i] = ent[i+1];
                end
                ent[CODE_DIGITS-1] = q_item.digit;
                if (cnt < CNT_W'(CODE_DIGITS)) begin
                  cnt = cnt + 1'b1;
                end
                do_check = (cnt >= CNT_W'(CODE_DIGITS));
              end else begin
                msg_c = MSG_DOOR_OPEN;
              end
            end
            // full entry check
            if (do_check) begin
              phase_nxt = PH_CHECK;
              case (md)
                MD_NORMAL: begin
                  if (ent == stored_r) begin
                    granted_c    = 1'b1;
                    w            = '0;
                    lock_len_nxt = {1'b0, cfg.init_lock};
                    msg_c        = MSG_GRANTED;
                    phase_nxt    = PH_INPUT;
                  end else begin
                    if (w < WRONG_SAT) begin
                      w = w + 1'b1;
                    end
                    if (w >= cfg.max_wrong) begin
                      phase_nxt    = PH_LOCKED;
                      lock_rem_nxt = lock_len_r;
                      alarm_nxt    = 1'b1;
                      if (lock_len_r < {1'b0, cfg.lock_cap}) begin
                        lock_len_nxt = {lock_len_r[15:0], 1'b0};
                      end
                      msg_c = MSG_LOCKED;
                    end else begin
                      msg_c     = MSG_WRONG;
                      phase_nxt = PH_INPUT;
                    end
                  end
                  ent = '0;
                  cnt = '0;
                end
                MD_OLD: begin
                  if (ent == stored_r) begin
                    md        = MD_NEW;
                    phase_nxt = PH_INPUT;
                    msg_c     = MSG_NEW_PROMPT;
                    ent       = '0;
                    cnt       = '0;
                  end else begin
                    // entry stays full while the message is shown
                    msg_c       = MSG_WRONG_OLD;
                    showing_nxt = 1'b1;
                    msg_rem_nxt = cfg.msg_ticks;
                  end
                end
                MD_NEW: begin
                  cand_nxt  = ent;
                  md        = MD_CONFIRM;
                  phase_nxt = PH_INPUT;
                  msg_c     = MSG_CONFIRM;
                  ent       = '0;
                  cnt       = '0;
                end
                default: begin
                  if (ent == cand_r) begin
                    stored_nxt = cand_r;
                    msg_c      = MSG_CHANGED;
                  end else begin
                    msg_c = MSG_MISMATCH;
                  end
                  showing_nxt = 1'b1;
                  msg_rem_nxt = cfg.msg_ticks;
                end
              endcase
            end
          end
        end
      end
      REQ_STOP: begin
        alarm_nxt = 1'b0;
      end
      REQ_SHOW: begin
        if (phase_r != PH_LOCKED) begin
          ent   = '0;
          cnt   = '0;
          msg_c = MSG_ENTER;
        end
      end
      default: begin
        go = 1'b0;
      end
    endcase

    entry_nxt = ent;
    count_nxt = cnt;
    mode_nxt  = md;
    wrong_nxt = w;
  end

  // result slot holds until taken
  always_comb begin
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_r    <= reset_code();
      entry_r     <= '0;
      count_r     <= '0;
      phase_r     <= PH_INPUT;
      mode_r      <= MD_NORMAL;
      showing_r   <= 1'b0;
      wrong_r     <= '0;
      lock_len_r  <= {1'b0, RST_INIT_LOCK};
      lock_rem_r  <= '0;
      msg_rem_r   <= '0;
      alarm_r     <= 1'b0;
      held_r      <= 1'b0;
      clr_pend_r  <= 1'b0;
      chg_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        stored_r   <= stored_nxt;
        entry_r    <= entry_nxt;
        count_r    <= count_nxt;
        phase_r    <= phase_nxt;
        mode_r     <= mode_nxt;
        showing_r  <= showing_nxt;
        wrong_r    <= wrong_nxt;
        lock_len_r <= lock_len_nxt;
        lock_rem_r <= lock_rem_nxt;
        msg_rem_r  <= msg_rem_nxt;
        alarm_r    <= alarm_nxt;
        held_r     <= held_nxt;
        clr_pend_r <= clr_pend_nxt;
        chg_pend_r <= chg_pend_nxt;
      end
    end
  end

  // candidate code and result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cand_r      <= cand_nxt;
      granted_r   <= granted_c;
      locked_r    <= (phase_nxt == PH_LOCKED);
      alarm_out_r <= alarm_nxt;
      shown_r     <= 3'(count_nxt);
      message_r   <= msg_c;
      mode_out_r  <= mode_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_access_granted = granted_r;
  assign out_locked_out     = locked_r;
  assign out_intruder_alarm = alarm_out_r;
  assign out_digits_shown   = shown_r;
  assign out_message        = message_r;
  assign out_entry_mode     = mode_out_r;

  // lockout only starts from normal mode with no message up
  a_lock_normal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_LOCKED |-> mode_r == MD_NORMAL && !showing_r)
    else $error("lockout outside normal mode");

  // entry never holds more digits than the code
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CODE_DIGITS))
    else $error("entry count out of range");

  // a grant is never reported together with lockout or change mode
  a_grant_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && granted_r |-> !locked_r && mode_out_r == MD_NORMAL)
    else $error("grant with lockout or change mode");

  // a popped request always produces a result beat
  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid_r)
    else $error("request popped without result");

endmodule
`default_nettype wire

@@ rtl/keypad_code_lock_controller.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// keypad_code_lock_controller
// Keypad code lock: press detection, code entry and check, code change,
// wrong-try lockout with alarm, tick-driven lock and message timers.
//
// Usage:
//   Request beats arrive on in_* (valid/stall); each one yields exactly one
//   result beat on out_* (access pulse, lockout, alarm, digits shown,
//   message code, entry mode).
//   A front stage classifies request and key and pushes into a two-entry
//   queue; the back part runs one request per cycle while out_stall is low
//   against the lock state and writes the result into an output register.
//   Throughput: one beat per cycle while out_stall is low. An accepted beat is
//   registered in the queue, then popped into the result register, where
//   out_stall can hold it.
//   When out_stall is high the result register holds, the queue fills and
//   in_stall rises once both queue entries are taken.
//   pready is always high. Registers are written at byte address 4*i of the
//   APB-style port, by the user only while idle; the block does not check it.
//   Reset (rst_n low, synchronous) restores the configuration defaults,
//   the stored code 1,2,3,4, an empty entry and normal mode.
// ---------------------------------------------------------------------------
module keypad_code_lock_controller import kcl_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // request channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_req_type,
  input  wire logic [3:0]        in_key_code,
  input  wire logic              in_door_open,
  input  wire logic              in_tick,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_access_granted,
  output logic                   out_locked_out,
  output logic                   out_intruder_alarm,
  output logic [2:0]             out_digits_shown,
  output logic [3:0]             out_message,
  output logic [1:0]             out_entry_mode,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  cfg_t        cfg_r;
  logic        wr_en;
  logic [2:0]  reg_idx;
  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_empty;
  item_t       push_item;
  item_t       pop_item;

  // register file write
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fsm_enable <= RST_FSM_ENABLE;
      cfg_r.init_lock  <= RST_INIT_LOCK;
      cfg_r.lock_cap   <= RST_LOCK_CAP;
      cfg_r.max_wrong  <= RST_MAX_WRONG;
      cfg_r.msg_ticks  <= RST_MSG_TICKS;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FSM_ENABLE: cfg_r.fsm_enable <= pwdata[0];
        REG_INIT_LOCK:  cfg_r.init_lock  <= pwdata[15:0];
        REG_LOCK_CAP:   cfg_r.lock_cap   <= pwdata[15:0];
        REG_MAX_WRONG:  cfg_r.max_wrong  <= pwdata[1:0];
        REG_MSG_TICKS:  cfg_r.msg_ticks  <= pwdata[15:0];
        default:        cfg_r            <= cfg_r;
      endcase
    end
  end

  // register file read
  always_comb begin
    case (reg_idx)
      REG_FSM_ENABLE: prdata = {{(DATA_W-1){1'b0}}, cfg_r.fsm_enable};
      REG_INIT_LOCK:  prdata = {{(DATA_W-16){1'b0}}, cfg_r.init_lock};
      REG_LOCK_CAP:   prdata = {{(DATA_W-16){1'b0}}, cfg_r.lock_cap};
      REG_MAX_WRONG:  prdata = {{(DATA_W-2){1'b0}}, cfg_r.max_wrong};
      REG_MSG_TICKS:  prdata = {{(DATA_W-16){1'b0}}, cfg_r.msg_ticks};
      default:        prdata = '0;
    endcase
  end

  // front: accept and classify
  kcl_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_key_code  (in_key_code),
    .in_door_open (in_door_open),
    .in_tick      (in_tick),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  // queue between the two sides
  kcl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  // back: lock state and result register
  kcl_core u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_empty            (q_empty),
    .q_item             (pop_item),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_access_granted (out_access_granted),
    .out_locked_out     (out_locked_out),
    .out_intruder_alarm (out_intruder_alarm),
    .out_digits_shown   (out_digits_shown),
    .out_message        (out_message),
    .out_entry_mode     (out_entry_mode)
  );

endmodule
`default_nettype wire

@@ dv/tb_keypad_code_lock_controller.sv @@
// ---------------------------------------------------------------------------
// tb_keypad_code_lock_controller
// Self-checking bench for the keypad code lock. A queue of request beats
// feeds a clocked driver; a clocked monitor compares every result beat with
// a behavioral lock model updated at each accepted request. Stimulus is a
// short directed run, then keypad sessions (good and bad codes, code change,
// clear, door open, lockout, alarm stop) mixed with noise over several
// register settings.
// ---------------------------------------------------------------------------
module tb_keypad_code_lock_controller import kcl_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT = 200000;
  localparam logic [3:0]  KEY_NONE    = 4'd15;

  typedef struct packed {
    req_t       req;
    logic [3:0] key;
    logic       door;
    logic       tick;
  } lock_beat_t;

  typedef struct packed {
    logic       granted;
    logic       locked;
    logic       alarm;
    logic [2:0] shown;
    msg_t       msg;
    mode_t      mode;
  } lock_result_t;

  // clock and reset
  logic clk;
  logic rst_n = 1'b0;

  // request channel
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [1:0] in_req_type  = '0;
  logic [3:0] in_key_code  = '0;
  logic       in_door_open = 1'b0;
  logic       in_tick      = 1'b0;

  // result channel
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_access_granted;
  logic       out_locked_out;
  logic       out_intruder_alarm;
  logic [2:0] out_digits_shown;
  logic [3:0] out_message;
  logic [1:0] out_entry_mode;

  // register port
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  keypad_code_lock_controller dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_key_code        (in_key_code),
    .in_door_open       (in_door_open),
    .in_tick            (in_tick),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_access_granted (out_access_granted),
    .out_locked_out     (out_locked_out),
    .out_intruder_alarm (out_intruder_alarm),
    .out_digits_shown   (out_digits_shown),
    .out_message        (out_message),
    .out_entry_mode     (out_entry_mode),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // bench bookkeeping
  lock_beat_t   pending_beats[$];
  lock_result_t lock_results_due[$];
  lock_beat_t   live_beat;
  lock_result_t predicted_result;
  lock_result_t due_result;
  lock_result_t seen_result;
  int           beats_queued  = 0;
  int           beats_sent    = 0;
  int           error_count   = 0;
  int           cycle_count   = 0;
  logic         quiet_span;

  // no idling or stalling while this window of beats goes through
  assign quiet_span = (beats_sent >= 450) && (beats_sent < 650);

  // lock model: configuration
  logic        cfg_enable    = RST_FSM_ENABLE;
  logic [15:0] cfg_init_lock = RST_INIT_LOCK;
  logic [15:0] cfg_lock_cap  = RST_LOCK_CAP;
  logic [1:0]  cfg_max_wrong = RST_MAX_WRONG;
  logic [15:0] cfg_msg_ticks = RST_MSG_TICKS;

  // lock model: state (stored code starts as 1,2,3,4 from digit 0 up)
  code_t       saved_code   = {4'd4, 4'd3, 4'd2, 4'd1};
  code_t       typed_digits = '0;
  code_t       pending_code = '0;
  logic [2:0]  typed_count  = '0;
  phase_t      lock_phase   = PH_INPUT;
  mode_t       cur_mode     = MD_NORMAL;
  logic        msg_active   = 1'b0;
  logic [1:0]  miss_count   = '0;
  logic [16:0] lockout_len  = {1'b0, RST_INIT_LOCK};
  logic [16:0] lockout_left = '0;
  logic [15:0] msg_left     = '0;
  logic        alarm_on     = 1'b0;
  logic        key_down     = 1'b0;
  logic        star_waiting = 1'b0;
  logic        hash_waiting = 1'b0;

  task automatic wipe_entry();
    typed_digits = '0;
    typed_count  = '0;
  endtask

  // full entry: compare, step through code change, or count a miss
  task automatic judge_entry(inout msg_t note, inout logic hit);
    case (cur_mode)
      MD_NORMAL: begin
        if (typed_digits == saved_code) begin
          hit         = 1'b1;
          miss_count  = '0;
          lockout_len = {1'b0, cfg_init_lock};
          note        = MSG_GRANTED;
          lock_phase  = PH_INPUT;
          wipe_entry();
        end else begin
          if (miss_count < WRONG_SAT) miss_count++;
          wipe_entry();
          if (miss_count >= cfg_max_wrong) begin
            lock_phase   = PH_LOCKED;
            lockout_left = lockout_len;
            alarm_on     = 1'b1;
            if (lockout_len < {1'b0, cfg_lock_cap}) lockout_len = {lockout_len[15:0], 1'b0};
            note = MSG_LOCKED;
          end else begin
            note       = MSG_WRONG;
            lock_phase = PH_INPUT;
          end
        end
      end
      MD_OLD: begin
        if (typed_digits == saved_code) begin
          cur_mode   = MD_NEW;
          lock_phase = PH_INPUT;
          note       = MSG_NEW_PROMPT;
          wipe_entry();
        end else begin
          // entry stays on display until the message times out
          note       = MSG_WRONG_OLD;
          msg_active = 1'b1;
          msg_left   = cfg_msg_ticks;
        end
      end
      MD_NEW: begin
        pending_code = typed_digits;
        cur_mode     = MD_CONFIRM;
        lock_phase   = PH_INPUT;
        note         = MSG_CONFIRM;
        wipe_entry();
      end
      default: begin
        if (typed_digits == pending_code) begin
          saved_code = pending_code;
          note       = MSG_CHANGED;
        end else begin
          note = MSG_MISMATCH;
        end
        msg_active = 1'b1;
        msg_left   = cfg_msg_ticks;
      end
    endcase
  endtask

  // one service step: timers first, then pending '#' and '*', then the key
  task automatic serve_keypad(input logic [3:0] key, input logic door, input logic tk,
                              inout msg_t note, inout logic hit);
    logic fresh_digit;
    fresh_digit = 1'b0;
    if (msg_active) begin
      if (tk && msg_left != 0) msg_left = msg_left - 16'd1;
      if (msg_left == 0) begin
        msg_active = 1'b0;
        cur_mode   = MD_NORMAL;
        lock_phase = PH_INPUT;
        wipe_entry();
        note = MSG_ENTER;
      end
      return;
    end
    if (lock_phase == PH_LOCKED) begin
      if (tk && lockout_left != 0) lockout_left = lockout_left - 17'd1;
      if (lockout_left != 0) return;
      miss_count = '0;
      alarm_on   = 1'b0;
      wipe_entry();
      note = MSG_LOCK_ENDED;
    end
    lock_phase = PH_INPUT;
    if (hash_waiting) begin
      hash_waiting = 1'b0;
      if (cur_mode == MD_NORMAL) begin
        cur_mode = MD_OLD;
        note     = MSG_OLD_PROMPT;
      end else begin
        cur_mode = MD_NORMAL;
        note     = MSG_CANCELLED;
      end
      wipe_entry();
    end
    if (star_waiting) begin
      star_waiting = 1'b0;
      if (cur_mode != MD_NORMAL || !door) wipe_entry();
    end
    // press detection: codes above '#' count as released
    if (key <= KEY_HASH_CODE) begin
      if (!key_down) begin
        key_down = 1'b1;
        if (key <= KEY_MAX_DIGIT) fresh_digit = 1'b1;
        else if (key == KEY_STAR_CODE) star_waiting = 1'b1;
        else hash_waiting = 1'b1;
      end
    end else begin
      key_down = 1'b0;
    end
    if (fresh_digit) begin
      if (cur_mode != MD_NORMAL || !door) begin
        typed_digits = {key, typed_digits[CODE_DIGITS-1:1]};
        if (typed_count < CODE_DIGITS) typed_count++;
        if (typed_count >= CODE_DIGITS) lock_phase = PH_CHECK;
      end else begin
        note = MSG_DOOR_OPEN;
      end
    end
    if (lock_phase == PH_CHECK) judge_entry(note, hit);
  endtask

  task automatic advance_lock(input lock_beat_t b, output lock_result_t r);
    msg_t note;
    logic hit;
    note = MSG_NONE;
    hit  = 1'b0;
    case (b.req)
      REQ_SERVICE: if (cfg_enable) serve_keypad(b.key, b.door, b.tick, note, hit);
      REQ_STOP:    alarm_on = 1'b0;
      REQ_SHOW: begin
        if (lock_phase != PH_LOCKED) begin
          wipe_entry();
          note = MSG_ENTER;
        end
      end
      default: ;
    endcase
    r.granted = hit;
    r.locked  = (lock_phase == PH_LOCKED);
    r.alarm   = alarm_on;
    r.shown   = typed_count;
    r.msg     = note;
    r.mode    = cur_mode;
  endtask

  // request driver: hold each beat until accepted, predict on acceptance
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        advance_lock(live_beat, predicted_result);
        lock_results_due.push_back(predicted_result);
        beats_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() != 0 && (quiet_span || $urandom_range(0, 99) >= 7)) begin
          live_beat    = pending_beats.pop_front();
          in_valid     <= 1'b1;
          in_req_type  <= live_beat.req;
          in_key_code  <= live_beat.key;
          in_door_open <= live_beat.door;
          in_tick      <= live_beat.tick;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen_result.granted = out_access_granted;
        seen_result.locked  = out_locked_out;
        seen_result.alarm   = out_intruder_alarm;
        seen_result.shown   = out_digits_shown;
        seen_result.msg     = msg_t'(out_message);
        seen_result.mode    = mode_t'(out_entry_mode);
        if (lock_results_due.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("result beat with nothing expected");
        end else begin
          due_result = lock_results_due.pop_front();
          if (seen_result !== due_result) begin
            error_count++;
            if (error_count <= 10) begin
              $display("mismatch exp: granted=%0d locked=%0d alarm=%0d shown=%0d msg=%0d mode=%0d",
                       due_result.granted, due_result.locked, due_result.alarm,
                       due_result.shown, due_result.msg, due_result.mode);
              $display("         got: granted=%0d locked=%0d alarm=%0d shown=%0d msg=%0d mode=%0d",
                       seen_result.granted, seen_result.locked, seen_result.alarm,
                       seen_result.shown, seen_result.msg, seen_result.mode);
            end
          end
        end
      end
      out_stall <= !quiet_span && ($urandom_range(0, 99) < 7);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // register write: setup then access phase
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FSM_ENABLE: cfg_enable    = value[0];
      REG_INIT_LOCK:  cfg_init_lock = value[15:0];
      REG_LOCK_CAP:   cfg_lock_cap  = value[15:0];
      REG_MAX_WRONG:  cfg_max_wrong = value[1:0];
      REG_MSG_TICKS:  cfg_msg_ticks = value[15:0];
      default: ;
    endcase
  endtask

  task automatic program_lock(input logic en, input int init_lock, input int cap,
                              input int max_wrong, input int msg_ticks);
    write_reg(REG_FSM_ENABLE, 32'(en));
    write_reg(REG_INIT_LOCK,  32'(init_lock));
    write_reg(REG_LOCK_CAP,   32'(cap));
    write_reg(REG_MAX_WRONG,  32'(max_wrong));
    write_reg(REG_MSG_TICKS,  32'(msg_ticks));
  endtask

  // wait until every queued beat has gone in and its result came out
  task automatic wait_quiet();
    while (pending_beats.size() != 0 || in_valid || lock_results_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic queue_beat(input req_t req, input logic [3:0] key, input logic door,
                            input logic tk);
    lock_beat_t b;
    b.req  = req;
    b.key  = key;
    b.door = door;
    b.tick = tk;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  // one key press: key down, then a release with one of the no-key codes
  task automatic press_key(input logic [3:0] key, input logic door);
    queue_beat(REQ_SERVICE, key, door, 1'($urandom_range(0, 1)));
    queue_beat(REQ_SERVICE, 4'($urandom_range(12, 15)), door, 1'($urandom_range(0, 1)));
  endtask

  task automatic enter_code(input code_t c, input int door_pct);
    for (int i = 0; i < CODE_DIGITS; i++)
      press_key(c[i], $urandom_range(0, 99) < door_pct);
  endtask

  function automatic code_t any_code();
    code_t c;
    for (int i = 0; i < CODE_DIGITS; i++) c[i] = 4'($urandom_range(0, 9));
    return c;
  endfunction

  // bring the lock to normal input and load its lock length with a good code
  task automatic ready_for_entry();
    do begin
      queue_beat(REQ_SERVICE, KEY_NONE, 1'b0, 1'b1);
      wait_quiet();
    end while (msg_active || lock_phase == PH_LOCKED);
    if (cur_mode != MD_NORMAL) begin
      press_key(KEY_HASH_CODE, 1'b0);
      wait_quiet();
    end
    // drop any partial entry before the good code
    queue_beat(REQ_SHOW, KEY_NONE, 1'b0, 1'b0);
    enter_code(saved_code, 0);
    wait_quiet();
  endtask

  // one randomly chosen keypad session
  task automatic queue_session();
    int    pick;
    int    n;
    code_t c;
    pick = $urandom_range(0, 99);
    if ((lock_phase == PH_LOCKED || msg_active) && pick < 70) begin
      // let timers run out, with the odd alarm stop or screen request
      n = $urandom_range(3, 10);
      repeat (n) queue_beat(REQ_SERVICE, KEY_NONE, 1'($urandom_range(0, 1)),
                            $urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) queue_beat(REQ_STOP, 4'($urandom_range(0, 15)),
                                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 5) == 0) queue_beat(REQ_SHOW, KEY_NONE, 1'b0, 1'b1);
    end else if (pick < 30) begin
      enter_code(saved_code, 10);
    end else if (pick < 45) begin
      enter_code(any_code(), 10);
    end else if (pick < 62) begin
      // code change: '#', old code, new code, confirm
      press_key(KEY_HASH_CODE, 1'($urandom_range(0, 1)));
      enter_code(($urandom_range(0, 9) != 0) ? saved_code : any_code(), 30);
      c = any_code();
      enter_code(c, 30);
      enter_code(($urandom_range(0, 3) != 0) ? c : any_code(), 30);
    end else if (pick < 70) begin
      // partial entry cleared by '*'
      n = $urandom_range(1, CODE_DIGITS - 1);
      repeat (n) press_key(4'($urandom_range(0, 9)), 1'b0);
      press_key(KEY_STAR_CODE, $urandom_range(0, 3) == 0);
    end else if (pick < 77) begin
      n = $urandom_range(1, 3);
      repeat (n) press_key(4'($urandom_range(0, 9)), 1'b1);
    end else if (pick < 85) begin
      queue_beat(req_t'(2'($urandom_range(1, 3))), 4'($urandom_range(0, 15)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else begin
      // raw noise, held keys included
      n = $urandom_range(1, 6);
      repeat (n) queue_beat(req_t'(2'($urandom_range(0, 3))), 4'($urandom_range(0, 15)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_sessions(input int count);
    int stop_at;
    stop_at = beats_queued + count;
    while (beats_queued < stop_at) begin
      while (pending_beats.size() > 1) @(posedge clk);
      queue_session();
    end
  endtask

  // stimulus sequence
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed run at reset settings
    queue_beat(REQ_NOP, 4'd0, 1'b1, 1'b1);
    queue_beat(REQ_SHOW, KEY_NONE, 1'b0, 1'b0);
    enter_code(saved_code, 0);
    press_key(4'd9, 1'b1);
    press_key(4'd0, 1'b0);
    press_key(KEY_STAR_CODE, 1'b1);
    press_key(KEY_STAR_CODE, 1'b0);
    press_key(KEY_HASH_CODE, 1'b0);
    press_key(KEY_HASH_CODE, 1'b0);
    queue_beat(REQ_STOP, KEY_NONE, 1'b0, 1'b0);
    queue_beat(REQ_SERVICE, KEY_NONE, 1'b0, 1'b1);
    wait_quiet();

    // short timers, lockout after two misses
    program_lock(1'b1, 4, 16, 2, 3);
    ready_for_entry();
    run_sessions(300);
    wait_quiet();

    // lowest settings
    program_lock(1'b1, 1, 1, 1, 1);
    ready_for_entry();
    run_sessions(250);
    wait_quiet();

    // disabled, registers at their top values
    program_lock(1'b0, 65535, 65535, 3, 65535);
    run_sessions(80);
    wait_quiet();

    program_lock(1'b1, 3, 40, 3, 5);
    ready_for_entry();
    run_sessions(300);
    wait_quiet();

    program_lock(1'b1, 5, 8, 2, 2);
    ready_for_entry();
    run_sessions(220);
    wait_quiet();

    repeat (10) @(posedge clk);
    if (error_count == 0 && lock_results_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
